// File: design/mgs_pkg.sv
// Shared types and codes of the multirate group scheduler.
`default_nettype none

package mgs_pkg;

	localparam int TIME_W  = 64;
	localparam int PHASE_W = 8;
	localparam int GIDX_W  = 3;

	// action codes carried in s_tuser
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_RUN     = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_RESTART = 5'b00010,
		ST_SCAN    = 5'b00100,
		ST_DECIDE  = 5'b01000,
		ST_ACK     = 5'b10000
	} state_t;

	// static part of one table entry
	typedef struct packed {
		logic [TIME_W-1:0]  period;
		logic [TIME_W-1:0]  offset;
		logic [PHASE_W-1:0] phase;
	} group_cfg_t;

	// entry offered to the pick unit
	typedef struct packed {
		logic               valid;
		logic [TIME_W-1:0]  t;
		logic [TIME_W-1:0]  period;
		logic [PHASE_W-1:0] phase;
	} cand_t;

	// best due entry found so far
	typedef struct packed {
		logic               found;
		logic [TIME_W-1:0]  t;
		logic [TIME_W-1:0]  period;
		logic [PHASE_W-1:0] phase;
	} pick_t;

endpackage

`default_nettype wire

// File: design/mgs_pick_unit.sv
// Shared compare unit: keeps the earliest due group over a one-entry-per-cycle scan.
`default_nettype none

module mgs_pick_unit #(
	parameter int IW = 3
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            clr,
	input  wire                            step,
	input  mgs_pkg::cand_t                 cand,
	input  wire [IW-1:0]                   cand_idx,
	input  wire [mgs_pkg::TIME_W-1:0]      limit,
	output mgs_pkg::pick_t                 best,
	output logic [IW-1:0]                  best_idx
);

	mgs_pkg::pick_t best_q;
	logic [IW-1:0]  best_idx_q;
	logic           win;

	// earlier time wins; equal time goes to lower phase; scan order gives lower index
	always_comb begin
		win = cand.valid && (cand.t <= limit) &&
			(!best_q.found || (cand.t < best_q.t) ||
			((cand.t == best_q.t) && (cand.phase < best_q.phase)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else begin
			priority if (clr) begin
				best_q.found <= 1'b0;
			end else if (step && win) begin
				best_q <= '{found: 1'b1, t: cand.t, period: cand.period, phase: cand.phase};
			end else begin
				best_q <= best_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && win && !clr) begin
			best_idx_q <= cand_idx;
		end
	end

	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule

`default_nettype wire

// File: design/multirate_group_scheduler_unit.sv
// Top level of the multirate group scheduler: group table, sequencer and result register.
//
// A table of GROUPS periodic rate groups is held in two small memories (static
// period/offset/phase, and the next activation time) plus one valid flip-flop
// per group. A load item (s_tuser = 0) writes one group and then returns its
// acknowledge beat. A restart item (s_tuser = 2) copies every offset back to the
// next time in a sweep of one entry per cycle. A run item (s_tuser = 1) carries
// a timestamp; the block repeatedly scans the table with a single shared compare
// unit, one entry per cycle, to find the earliest due group (ties: lower phase,
// then lower index), emits it and advances it by its period with saturation at
// all ones. At most MAX_BURST activations come out per run item; when more
// remain due the last beat raises more_pending. A run with nothing due, a load
// and a restart each return one beat with fired = 0 and tlast = 1. The block
// takes one item at a time: s_tready is high only between items. Each result
// is held in an output register, so a stalled m_tready only stretches the work,
// it never drops a beat.
`default_nettype none

module multirate_group_scheduler_unit #(
	parameter int GROUPS    = 8,
	parameter int MAX_BURST = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// s_tdata, low bit up: group_index[2:0], period_ns[66:3], offset_ns[130:67],
	// phase_order[138:131], timestamp_ns[202:139], zero pad[207:203]
	input  wire  [207:0] s_tdata,
	// s_tuser: action[1:0]
	input  wire  [1:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// m_tdata, low bit up: fired_group[2:0], activation_time_ns[66:3],
	// more_pending[67], zero pad[71:68]
	output logic [71:0]  m_tdata,
	// m_tuser: fired
	output logic         m_tuser,
	output logic         m_tlast
);

	localparam int IW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int CW = $clog2(GROUPS + 1);
	localparam int BW = $clog2(MAX_BURST + 1);
	localparam int TW = mgs_pkg::TIME_W;

	// input fields
	logic [1:0]                    in_action;
	logic [mgs_pkg::GIDX_W-1:0]    in_group;
	logic [TW-1:0]                 in_period;
	logic [TW-1:0]                 in_offset;
	logic [mgs_pkg::PHASE_W-1:0]   in_phase;
	logic [TW-1:0]                 in_ts;

	assign in_action = s_tuser;
	assign in_group  = s_tdata[2:0];
	assign in_period = s_tdata[66:3];
	assign in_offset = s_tdata[130:67];
	assign in_phase  = s_tdata[138:131];
	assign in_ts     = s_tdata[202:139];

	// group table
	mgs_pkg::group_cfg_t cfg_mem  [GROUPS];
	logic [TW-1:0]       next_mem [GROUPS];
	logic [GROUPS-1:0]   valid_q;
	mgs_pkg::group_cfg_t rd_cfg_q;
	logic [TW-1:0]       rd_next_q;

	// sequencer
	mgs_pkg::state_t state_q;
	logic [CW-1:0]   cnt_q;
	logic [BW-1:0]   burst_q;
	logic            held_q;
	logic [IW-1:0]   held_idx_q;
	logic [TW-1:0]   held_t_q;
	logic [TW-1:0]   limit_q;

	// result register
	logic                      out_valid_q;
	logic                      out_fired_q;
	logic [mgs_pkg::GIDX_W-1:0] out_grp_q;
	logic [TW-1:0]             out_time_q;
	logic                      out_pend_q;
	logic                      out_last_q;

	// pick unit
	mgs_pkg::cand_t cand;
	mgs_pkg::pick_t best;
	logic [IW-1:0]  best_idx;
	logic           pick_clr;
	logic           pick_step;

	logic          in_acc;
	logic          ld_ok;
	logic [IW-1:0] ld_idx;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] e_idx;
	logic          slot_free;
	logic          scan_done;
	logic          burst_full;
	logic          emit_last;
	logic          fire;
	logic          emit_held;
	logic          emit_ack;
	logic [TW:0]   sum;
	logic [TW-1:0] sat_next;
	logic          next_we;
	logic [IW-1:0] next_wa;
	logic [TW-1:0] next_wd;

	always_comb begin
		in_acc     = s_tvalid && s_tready;
		ld_ok      = (32'(in_group) < GROUPS);
		ld_idx     = IW'(in_group);
		rd_addr    = (cnt_q < CW'(GROUPS)) ? cnt_q[IW-1:0] : '0;
		e_idx      = IW'(cnt_q - CW'(1));
		slot_free  = !out_valid_q || m_tready;
		scan_done  = (cnt_q == CW'(GROUPS));
		burst_full = (burst_q == BW'(MAX_BURST));
		emit_last  = !best.found || burst_full;
		fire       = (state_q == mgs_pkg::ST_DECIDE) && best.found &&
			(!held_q || (slot_free && !emit_last));
		emit_held  = (state_q == mgs_pkg::ST_DECIDE) && held_q && slot_free;
		emit_ack   = (state_q == mgs_pkg::ST_ACK) && slot_free;
		// saturating advance of the picked group
		sum        = {1'b0, best.t} + {1'b0, best.period};
		sat_next   = sum[TW] ? '1 : sum[TW-1:0];
	end

	// one write port on the next-time memory
	always_comb begin
		next_we = 1'b0;
		next_wa = ld_idx;
		next_wd = in_offset;
		priority if (in_acc && (in_action == mgs_pkg::ACT_LOAD) && ld_ok) begin
			next_we = 1'b1;
		end else if ((state_q == mgs_pkg::ST_RESTART) && (cnt_q != '0)) begin
			next_we = 1'b1;
			next_wa = e_idx;
			next_wd = rd_cfg_q.offset;
		end else if (fire) begin
			next_we = 1'b1;
			next_wa = best_idx;
			next_wd = sat_next;
		end else begin
			next_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_cfg_q  <= cfg_mem[rd_addr];
		rd_next_q <= next_mem[rd_addr];
		if (in_acc && (in_action == mgs_pkg::ACT_LOAD) && ld_ok) begin
			cfg_mem[ld_idx] <= '{period: in_period, offset: in_offset, phase: in_phase};
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
	end

	// scan feeds the entry read in the previous cycle
	always_comb begin
		pick_clr    = (state_q == mgs_pkg::ST_SCAN) && (cnt_q == '0);
		pick_step   = (state_q == mgs_pkg::ST_SCAN) && (cnt_q != '0);
		cand.valid  = valid_q[e_idx];
		cand.t      = rd_next_q;
		cand.period = rd_cfg_q.period;
		cand.phase  = rd_cfg_q.phase;
	end

	mgs_pick_unit #(
		.IW (IW)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (pick_clr),
		.step     (pick_step),
		.cand     (cand),
		.cand_idx (e_idx),
		.limit    (limit_q),
		.best     (best),
		.best_idx (best_idx)
	);

	assign s_tready = (state_q == mgs_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mgs_pkg::ST_IDLE;
			cnt_q   <= '0;
			burst_q <= '0;
			held_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			unique case (state_q)
				mgs_pkg::ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0;
						priority if (in_action == mgs_pkg::ACT_RUN) begin
							burst_q <= '0;
							held_q  <= 1'b0;
							state_q <= mgs_pkg::ST_SCAN;
						end else if (in_action == mgs_pkg::ACT_RESTART) begin
							state_q <= mgs_pkg::ST_RESTART;
						end else begin
							// load, and the unused code, just ack
							if ((in_action == mgs_pkg::ACT_LOAD) && ld_ok) begin
								valid_q[ld_idx] <= 1'b1;
							end
							state_q <= mgs_pkg::ST_ACK;
						end
					end
				end
				mgs_pkg::ST_RESTART: begin
					cnt_q <= cnt_q + CW'(1);
					if (scan_done) begin
						state_q <= mgs_pkg::ST_ACK;
					end
				end
				mgs_pkg::ST_SCAN: begin
					cnt_q <= cnt_q + CW'(1);
					if (scan_done) begin
						state_q <= mgs_pkg::ST_DECIDE;
					end
				end
				mgs_pkg::ST_DECIDE: begin
					if (fire) begin
						held_q  <= 1'b1;
						burst_q <= burst_q + BW'(1);
						cnt_q   <= '0;
						state_q <= mgs_pkg::ST_SCAN;
					end else if (emit_held) begin
						state_q <= mgs_pkg::ST_IDLE;
					end else if (!held_q) begin
						// nothing due at all
						state_q <= mgs_pkg::ST_ACK;
					end
				end
				mgs_pkg::ST_ACK: begin
					if (slot_free) begin
						state_q <= mgs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mgs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload of the sequencer
	always_ff @(posedge clk) begin
		if (in_acc && (in_action == mgs_pkg::ACT_RUN)) begin
			limit_q <= in_ts;
		end
		if (fire) begin
			held_idx_q <= best_idx;
			held_t_q   <= best.t;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_held || emit_ack) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_held) begin
			out_fired_q <= 1'b1;
			out_grp_q   <= mgs_pkg::GIDX_W'(held_idx_q);
			out_time_q  <= held_t_q;
			out_pend_q  <= best.found && burst_full;
			out_last_q  <= emit_last;
		end else if (emit_ack) begin
			out_fired_q <= 1'b0;
			out_grp_q   <= '0;
			out_time_q  <= '0;
			out_pend_q  <= 1'b0;
			out_last_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_fired_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0, out_pend_q, out_time_q, out_grp_q};

	// burst counter never runs past the limit
	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q <= BW'(MAX_BURST))
		else $error("burst count beyond limit");

	// a pending flag only ever sits on the closing beat of a run
	a_pend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_pend_q) |-> (m_tlast && m_tuser))
		else $error("more_pending on a beat that is not last");

	// an acknowledge or empty run is always a single closing beat
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tlast)
		else $error("non-activation beat without tlast");

	// a held activation always has been counted
	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> (burst_q != '0))
		else $error("held activation with zero burst count");

	// a fire always restarts the scan from the first entry
	a_fire_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (state_q == mgs_pkg::ST_SCAN) && (cnt_q == '0))
		else $error("fire did not restart the scan");

endmodule

`default_nettype wire

// File: tb/sv/tb_multirate_group_scheduler_unit.sv
// Self-checking testbench of the multirate group scheduler: stream driver, result monitor, predictor.
`timescale 1ns / 100ps

module tb_multirate_group_scheduler_unit;

	localparam int GROUPS    = 8;
	localparam int MAX_BURST = 16;

	// code 3 is not decoded by the block; it must still ack
	localparam logic [1:0]  ACT_UNUSED = 2'd3;
	localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          DRAIN_CYCLES = 200;

	// one input item, unpacked
	typedef struct {
		logic [1:0]  action;
		logic [2:0]  gidx;
		logic [63:0] period;
		logic [63:0] offset;
		logic [7:0]  phase;
		logic [63:0] stamp;
	} sched_cmd_t;

	// one result beat, unpacked
	typedef struct {
		logic        fired;
		logic [2:0]  grp;
		logic [63:0] t;
		logic        pend;
		logic        is_last;
	} sched_beat_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [207:0] s_tdata = '0;
	logic [1:0]   s_tuser = mgs_pkg::ACT_LOAD;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;
	logic         m_tuser;
	logic         m_tlast;

	multirate_group_scheduler_unit #(
		.GROUPS   (GROUPS),
		.MAX_BURST(MAX_BURST)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// --- predictor state: our own copy of the group table ---
	logic        grp_valid  [GROUPS] = '{default: 1'b0};
	logic [63:0] grp_period [GROUPS];
	logic [63:0] grp_offset [GROUPS];
	logic [7:0]  grp_phase  [GROUPS];
	logic [63:0] grp_next   [GROUPS];

	sched_cmd_t  cmd_q[$];        // items still to be sent
	sched_beat_t activation_q[$]; // predicted beats not yet seen
	sched_beat_t want;
	int          errors = 0;
	int          hold_left = 0;   // sender gap counter
	int          stall_left = 0;  // receiver stall counter
	bit          drv_quiet = 1'b0;
	bit          rdy_quiet = 1'b0;
	logic [63:0] now_ns;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly zero, some short, a few long gaps. The quiet flag flips now and
	// then and gives stretches with no idling at all.
	function automatic int pick_gap(inout bit quiet);
		int r;
		if ($urandom_range(0, 19) == 0)
			quiet = !quiet;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Earliest valid group due at or before limit; ties on time go to the
	// lower phase, then to the lower index (strict compare keeps the first).
	function automatic int earliest_due(logic [63:0] limit);
		int          sel;
		logic [63:0] best_t;
		logic [7:0]  best_p;
		sel = -1;
		best_t = '0;
		best_p = '0;
		for (int i = 0; i < GROUPS; i++) begin
			if (!grp_valid[i] || grp_next[i] > limit)
				continue;
			if (sel < 0 || grp_next[i] < best_t ||
			    (grp_next[i] == best_t && grp_phase[i] < best_p)) begin
				sel = i;
				best_t = grp_next[i];
				best_p = grp_phase[i];
			end
		end
		return sel;
	endfunction

	// Applies one accepted item to the table and queues the beats it causes.
	function automatic void schedule_item(sched_cmd_t c);
		sched_beat_t held;
		int          n;
		int          g;
		logic [63:0] t;
		held = '{fired: 1'b0, grp: 3'd0, t: 64'd0, pend: 1'b0, is_last: 1'b1};
		n = 0;
		case (c.action)
			mgs_pkg::ACT_RUN: begin
				while (n < MAX_BURST) begin
					g = earliest_due(c.stamp);
					if (g < 0)
						break;
					t = grp_next[g];
					// saturating advance
					grp_next[g] = (t > ALL_ONES - grp_period[g]) ? ALL_ONES : t + grp_period[g];
					if (n > 0)
						activation_q.insert(activation_q.size(), held);
					held = '{fired: 1'b1, grp: 3'(g), t: t, pend: 1'b0, is_last: 1'b0};
					n++;
				end
				held.is_last = 1'b1;
				if (n == MAX_BURST && earliest_due(c.stamp) >= 0)
					held.pend = 1'b1;
			end
			mgs_pkg::ACT_LOAD: begin
				if (c.gidx < GROUPS) begin
					grp_valid[c.gidx]  = 1'b1;
					grp_period[c.gidx] = c.period;
					grp_offset[c.gidx] = c.offset;
					grp_phase[c.gidx]  = c.phase;
					grp_next[c.gidx]   = c.offset;
				end
			end
			mgs_pkg::ACT_RESTART: begin
				for (int i = 0; i < GROUPS; i++)
					grp_next[i] = grp_offset[i];
			end
			default: ; // unused code: ack only
		endcase
		activation_q.insert(activation_q.size(), held);
	endfunction

	function automatic void add_cmd(logic [1:0] action, logic [2:0] gidx, logic [63:0] period,
	                                logic [63:0] offset, logic [7:0] phase, logic [63:0] stamp);
		sched_cmd_t c;
		c = '{action: action, gidx: gidx, period: period, offset: offset,
		      phase: phase, stamp: stamp};
		cmd_q.insert(cmd_q.size(), c);
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// --- clock ---
	initial begin
		forever #5 clk = ~clk;
	end

	// --- sender: one item per beat, random gap after each accepted beat ---
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= mgs_pkg::ACT_LOAD;
			hold_left = 0;
		end else if (!s_tvalid || s_tready) begin
			// a beat moved at this edge: predict it, then roll the next gap
			if (s_tvalid) begin
				schedule_item(cmd_q.pop_front());
				hold_left = pick_gap(drv_quiet);
			end
			if (hold_left == 0 && cmd_q.size() > 0) begin
				s_tvalid <= 1'b1;
				// tdata, low bit up: group_index, period, offset, phase, timestamp, pad
				s_tdata <= {5'b0, cmd_q[0].stamp, cmd_q[0].phase, cmd_q[0].offset,
				            cmd_q[0].period, cmd_q[0].gidx};
				s_tuser <= cmd_q[0].action;
			end else begin
				if (hold_left > 0)
					hold_left--;
				s_tvalid <= 1'b0;
			end
		end
	end

	// --- receiver backpressure: stalls start at random on any cycle ---
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			stall_left = pick_gap(rdy_quiet);
			m_tready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// --- monitor: every accepted result against the oldest prediction ---
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (activation_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual fired=%b grp=%0d t=%h last=%b",
				         $time, m_tuser, m_tdata[2:0], m_tdata[66:3], m_tlast);
				errors++;
			end else begin
				want = activation_q.pop_front();
				check_field("fired", want.fired, m_tuser);
				check_field("fired_group", want.grp, m_tdata[2:0]);
				check_field("activation_time", want.t, m_tdata[66:3]);
				check_field("more_pending", want.pend, m_tdata[67]);
				check_field("tlast", want.is_last, m_tlast);
			end
		end
	end

	// --- stimulus and end of run ---
	initial begin
		int r;
		int sel;
		sched_cmd_t c;

		// Directed part. All eight groups get loaded before the first restart,
		// so a restart never copies an offset that was never written.
		add_cmd(mgs_pkg::ACT_RUN, 3'd5, rand64(), rand64(), 8'hA5, 64'd0);        // empty table
		add_cmd(ACT_UNUSED, 3'd7, rand64(), rand64(), 8'hFF, rand64());
		add_cmd(mgs_pkg::ACT_LOAD, 3'd0, 64'd10, 64'd0, 8'd5, rand64());
		add_cmd(mgs_pkg::ACT_LOAD, 3'd1, 64'd10, 64'd0, 8'd5, rand64());  // tie on phase -> index
		add_cmd(mgs_pkg::ACT_LOAD, 3'd2, 64'd10, 64'd0, 8'd0, rand64());  // lower phase wins
		add_cmd(mgs_pkg::ACT_LOAD, 3'd3, ALL_ONES, 64'd5, 8'd255, rand64()); // saturates at once
		add_cmd(mgs_pkg::ACT_LOAD, 3'd4, 64'd0, ALL_ONES, 8'd1, rand64());   // zero period, at top
		add_cmd(mgs_pkg::ACT_LOAD, 3'd5, 64'd1, ALL_ONES - 1, 8'd255, rand64()); // reaches all ones
		add_cmd(mgs_pkg::ACT_LOAD, 3'd6, 64'd7, 64'd3, 8'd128, rand64());
		add_cmd(mgs_pkg::ACT_LOAD, 3'd7, 64'd3, 64'd100, 8'h55, rand64());
		add_cmd(mgs_pkg::ACT_RUN, 3'd0, rand64(), rand64(), 8'd0, 64'd0);
		add_cmd(mgs_pkg::ACT_RUN, 3'd0, rand64(), rand64(), 8'd0, 64'd25);
		add_cmd(mgs_pkg::ACT_RUN, 3'd0, rand64(), rand64(), 8'd0, 64'd120);        // burst limit hit
		add_cmd(mgs_pkg::ACT_RUN, 3'd0, rand64(), rand64(), 8'd0, 64'd1000);
		add_cmd(mgs_pkg::ACT_RESTART, 3'd2, rand64(), rand64(), 8'd9, rand64());
		add_cmd(mgs_pkg::ACT_RUN, 3'd0, rand64(), rand64(), 8'd0, ALL_ONES);   // burst limit hit, group 3 saturates
		add_cmd(mgs_pkg::ACT_RUN, 3'd0, rand64(), rand64(), 8'd0, ALL_ONES);
		add_cmd(mgs_pkg::ACT_LOAD, 3'd4, 64'd0, 64'd50, 8'd0, rand64());       // zero period, reachable
		add_cmd(mgs_pkg::ACT_RUN, 3'd0, rand64(), rand64(), 8'd0, 64'd60);
		add_cmd(mgs_pkg::ACT_LOAD, 3'd4, 64'd5, 64'h8000_0000_0000_0000, 8'd200, rand64());
		add_cmd(mgs_pkg::ACT_RESTART, 3'd5, rand64(), rand64(), 8'd0, rand64());
		add_cmd(mgs_pkg::ACT_RUN, 3'd0, rand64(), rand64(), 8'd0, 64'd0);
		add_cmd(mgs_pkg::ACT_LOAD, 3'd3, ALL_ONES, 64'd0, 8'd0, rand64());
		add_cmd(mgs_pkg::ACT_RUN, 3'd0, rand64(), rand64(), 8'd0, ALL_ONES - 1);

		// Random part: mostly runs that creep forward in time over groups with
		// small periods, so each run fires a handful; loads keep the table
		// changing; rare wide values, restarts and unused codes as noise.
		// Fields an item does not use carry random content.
		now_ns = 64'd200;
		for (int k = 0; k < 126; k++) begin
			c = '{action: mgs_pkg::ACT_RUN, gidx: 3'($urandom), period: rand64(),
			      offset: rand64(), phase: 8'($urandom), stamp: rand64()};
			r = $urandom_range(0, 99);
			if (r < 55) begin
				now_ns = now_ns + $urandom_range(0, 40);
				c.stamp = now_ns;
			end else if (r < 75) begin
				c.action = mgs_pkg::ACT_LOAD;
				sel = $urandom_range(0, 19);
				if (sel == 0)
					c.period = 64'd0;
				else if (sel == 1)
					c.period = ALL_ONES;
				else if (sel > 4)
					c.period = $urandom_range(1, 30);
				if ($urandom_range(0, 9) > 1)
					c.offset = now_ns + $urandom_range(0, 50);
			end else if (r < 82) begin
				c.action = mgs_pkg::ACT_RESTART;
			end else if (r < 87) begin
				c.action = ACT_UNUSED;
			end else if (r < 93) begin
				c.stamp = rand64();
			end else if (r < 97) begin
				c.stamp = ALL_ONES;
			end else begin
				c.stamp = 64'd0;
			end
			cmd_q.insert(cmd_q.size(), c);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0)
			@(posedge clk);
		while (activation_q.size() != 0)
			@(posedge clk);
		// any stray beat after the last expected one is caught by the monitor
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// --- watchdog: several times the slowest legal run ---
	initial begin
		#6_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
